FILE: sv/itrf_pkg.sv
// itrf_pkg: shared types and constants of the i2c target register file
// no dependencies; imported by all modules
`default_nettype none

package itrf_pkg;

  typedef enum logic [1:0] {
    CMD_ADDR_MATCH = 2'd0,
    CMD_RX_BYTE    = 2'd1,
    CMD_TX_REQ     = 2'd2,
    CMD_STOP       = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    PH_ADDRESS  = 2'd0,
    PH_RECEIVE  = 2'd1,
    PH_TRANSMIT = 2'd2
  } phase_e;

  localparam logic [7:0] EMPTY_BYTE = 8'hEE;

  // store access request from the control unit
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } store_req_t;

  // per-beat result of the control unit, held in the first pipeline stage
  typedef struct packed {
    logic        is_tx;
    logic        in_range;
    logic [31:0] wr_cnt;
    logic [31:0] rd_cnt;
  } step_t;

endpackage

`default_nettype wire

FILE: sv/itrf_cfg_if.sv
// itrf_cfg_if: write channel for the buffer length register
// no dependencies
`default_nettype none

interface itrf_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/itrf_cmd_if.sv
// itrf_cmd_if: bus event channel into the register file
// no dependencies
`default_nettype none

interface itrf_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] rx_byte;

  modport source (output valid, output command, output rx_byte, input ready);
  modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: sv/itrf_rsp_if.sv
// itrf_rsp_if: result channel out of the register file
// no dependencies
`default_nettype none

interface itrf_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  tx_byte;
  logic        tx_valid;
  logic [31:0] write_transfers;
  logic [31:0] read_transfers;

  modport source (output valid, output tx_byte, output tx_valid,
                  output write_transfers, output read_transfers, input ready);
  modport sink   (input valid, input tx_byte, input tx_valid,
                  input write_transfers, input read_transfers, output ready);
endinterface

`default_nettype wire

FILE: sv/i2c_target_register_file.sv
// i2c_target_register_file: top level, two-stage pipeline around control and store
// depends on itrf_pkg, the three channel interfaces, itrf_ctrl and itrf_store
//
// Byte-level side of an I2C target with a register pointer. Each command beat is
// one bus event (address match, received byte, transmit request, stop) and gives
// exactly one response beat carrying the transmit byte, its flag and both
// transaction counters. A new event is taken every clock cycle while the first
// stage can advance; back-pressure on the response channel stalls it. Each event
// is held in the first stage while the store's registered read completes, then
// its response moves into the output register. The store is cleared at reset by
// per-entry valid bits, so no clearing pass is needed. Write the buffer length
// only while no event is in flight.
`default_nettype none

module i2c_target_register_file #(
  parameter int STORE_DEPTH = 256
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  itrf_cfg_if.sink   cfg_i,
  itrf_cmd_if.sink   cmd_i,
  itrf_rsp_if.source rsp_o
);
  import itrf_pkg::*;

  localparam int AddrWidth = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  logic                 accept;
  store_req_t           store_req;
  logic [AddrWidth-1:0] store_addr;
  logic [7:0]           store_rdata;
  step_t                step;

  logic                 s1_valid_q, s1_valid_d;
  step_t                s1_q;
  logic                 s1_adv;
  logic                 out_valid_q, out_valid_d;
  logic [7:0]           tx_byte_d;

  logic [7:0]           out_tx_byte_q;
  logic                 out_tx_valid_q;
  logic [31:0]          out_wr_cnt_q;
  logic [31:0]          out_rd_cnt_q;

  assign s1_adv      = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign cmd_i.ready = !s1_valid_q || s1_adv;
  assign accept      = cmd_i.valid && cmd_i.ready;

  itrf_ctrl #(
    .Depth     (STORE_DEPTH),
    .AddrWidth (AddrWidth)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_i),
    .accept_i  (accept),
    .command_i (cmd_i.command),
    .rx_byte_i (cmd_i.rx_byte),
    .req_o     (store_req),
    .addr_o    (store_addr),
    .step_o    (step)
  );

  itrf_store #(
    .Depth     (STORE_DEPTH),
    .AddrWidth (AddrWidth)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (store_req),
    .addr_i  (store_addr),
    .wdata_i (cmd_i.rx_byte),
    .rdata_o (store_rdata)
  );

  always_comb begin
    if (!s1_q.is_tx) begin
      tx_byte_d = 8'h00;
    end else if (s1_q.in_range) begin
      tx_byte_d = store_rdata;
    end else begin
      tx_byte_d = EMPTY_BYTE;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= step;
    end
    if (s1_adv) begin
      out_tx_byte_q  <= tx_byte_d;
      out_tx_valid_q <= s1_q.is_tx;
      out_wr_cnt_q   <= s1_q.wr_cnt;
      out_rd_cnt_q   <= s1_q.rd_cnt;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.tx_byte         = out_tx_byte_q;
  assign rsp_o.tx_valid        = out_tx_valid_q;
  assign rsp_o.write_transfers = out_wr_cnt_q;
  assign rsp_o.read_transfers  = out_rd_cnt_q;

  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |-> !cmd_i.ready)
    else $error("command accepted while first stage is stuck");

  a_accept_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted beat lost from first stage");

  a_idle_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.tx_valid) |-> (rsp_o.tx_byte == 8'h00))
    else $error("non-transmit response carries a byte");

  a_adv_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("first stage advanced without filling output register");

endmodule

`default_nettype wire

FILE: sv/itrf_store.sv
// itrf_store: register store memory with per-entry valid bits for reset-to-zero
// depends on itrf_pkg for the access request type
`default_nettype none

module itrf_store #(
  parameter int Depth     = 256,
  parameter int AddrWidth = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire itrf_pkg::store_req_t     req_i,
  input  wire logic [AddrWidth-1:0]     addr_i,
  input  wire logic [7:0]               wdata_i,
  output      logic [7:0]               rdata_o
);
  import itrf_pkg::*;

  logic [7:0]       mem_q [Depth];
  logic [7:0]       mem_rd_q;
  logic [Depth-1:0] vld_q;
  logic             vld_rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (req_i.rd_en) begin
      mem_rd_q <= mem_q[addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[addr_i] <= 1'b1;
      end
      if (req_i.rd_en) begin
        vld_rd_q <= vld_q[addr_i];
      end
    end
  end

  assign rdata_o = vld_rd_q ? mem_rd_q : 8'h00;

endmodule

`default_nettype wire

FILE: sv/itrf_ctrl.sv
// itrf_ctrl: phase, pointer, transfer counters and buffer length register
// depends on itrf_pkg and itrf_cfg_if
`default_nettype none

module itrf_ctrl #(
  parameter int Depth     = 256,
  parameter int AddrWidth = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  itrf_cfg_if.sink                  cfg_i,
  input  wire logic                 accept_i,
  input  wire logic [1:0]           command_i,
  input  wire logic [7:0]           rx_byte_i,
  output      itrf_pkg::store_req_t req_o,
  output      logic [AddrWidth-1:0] addr_o,
  output      itrf_pkg::step_t      step_o
);
  import itrf_pkg::*;

  logic [7:0]  buf_len_q;
  phase_e      phase_q, phase_d;
  logic [7:0]  pointer_q, pointer_d;
  logic [31:0] wr_cnt_q, wr_cnt_d;
  logic [31:0] rd_cnt_q, rd_cnt_d;
  logic        in_range;

  assign cfg_i.ready = 1'b1;

  // effective limit is the smaller of the length register and the store depth
  assign in_range = (pointer_q < buf_len_q) && ({1'b0, pointer_q} < 9'(Depth));

  always_comb begin
    phase_d     = phase_q;
    pointer_d   = pointer_q;
    wr_cnt_d    = wr_cnt_q;
    rd_cnt_d    = rd_cnt_q;
    req_o.wr_en = 1'b0;
    req_o.rd_en = 1'b0;
    if (accept_i) begin
      case (cmd_e'(command_i))
        CMD_ADDR_MATCH: begin
          phase_d = PH_ADDRESS;
        end
        CMD_RX_BYTE: begin
          if (phase_q == PH_ADDRESS) begin
            pointer_d = rx_byte_i;
          end else if ((pointer_q != 8'h00) && in_range) begin
            req_o.wr_en = 1'b1;
            pointer_d   = pointer_q + 8'h01;
          end
          phase_d = PH_RECEIVE;
        end
        CMD_TX_REQ: begin
          if (in_range) begin
            req_o.rd_en = 1'b1;
            pointer_d   = pointer_q + 8'h01;
          end
          phase_d = PH_TRANSMIT;
        end
        CMD_STOP: begin
          case (phase_q)
            PH_TRANSMIT: rd_cnt_d = rd_cnt_q + 32'd1;
            PH_RECEIVE:  wr_cnt_d = wr_cnt_q + 32'd1;
            default:     ;
          endcase
        end
        default: ;
      endcase
    end
  end

  assign addr_o = pointer_q[AddrWidth-1:0];

  always_comb begin
    step_o.is_tx    = (cmd_e'(command_i) == CMD_TX_REQ);
    step_o.in_range = in_range;
    step_o.wr_cnt   = wr_cnt_d;
    step_o.rd_cnt   = rd_cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_len_q <= 8'h00;
      phase_q   <= PH_ADDRESS;
      pointer_q <= 8'h00;
      wr_cnt_q  <= 32'd0;
      rd_cnt_q  <= 32'd0;
    end else begin
      if (cfg_i.valid) begin
        buf_len_q <= cfg_i.data;
      end
      phase_q   <= phase_d;
      pointer_q <= pointer_d;
      wr_cnt_q  <= wr_cnt_d;
      rd_cnt_q  <= rd_cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: verif/tb_i2c_target_register_file.sv
// tb_i2c_target_register_file: self-checking testbench for the i2c target register file
// depends on itrf_pkg, itrf_cfg_if, itrf_cmd_if, itrf_rsp_if and i2c_target_register_file
// bus events go through a queue-fed driver, a predictor forms each reply, a monitor checks it

module tb_i2c_target_register_file;
  timeunit 1ns;
  timeprecision 1ps;

  import itrf_pkg::*;

  localparam int STORE_DEPTH = 256;
  localparam int EVENTS_PER_PHASE = 200;
  // buffer length per random phase, -1 picks one at random
  localparam int PHASE_LEN [9] = '{255, 1, 0, -1, 255, 2, 254, -1, 128};

  typedef struct {
    cmd_e       command;
    logic [7:0] rx_byte;
    bit         wait_drain;
  } bus_event_t;

  typedef struct {
    logic [7:0]  tx_byte;
    logic        tx_valid;
    logic [31:0] write_transfers;
    logic [31:0] read_transfers;
  } reply_t;

  logic clk;
  logic rst_n;

  itrf_cfg_if cfg_if ();
  itrf_cmd_if cmd_if ();
  itrf_rsp_if rsp_if ();

  i2c_target_register_file #(
    .STORE_DEPTH(STORE_DEPTH)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_if),
    .cmd_i (cmd_if),
    .rsp_o (rsp_if)
  );

  bus_event_t bus_events[$];
  reply_t     due_replies[$];
  int         events_queued;
  int         error_count;
  int         send_idle_pct;
  int         recv_idle_pct;

  // predictor state
  logic [7:0]  buffer_len;
  phase_e      bus_phase;
  logic [7:0]  reg_ptr;
  logic [7:0]  reg_image [STORE_DEPTH];
  logic [31:0] write_total;
  logic [31:0] read_total;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_i2c_target_register_file: done, errors");
    $finish;
  end

  function automatic reply_t apply_bus_event(cmd_e c, logic [7:0] b);
    reply_t r;
    int     lim;
    lim = (buffer_len < STORE_DEPTH) ? int'(buffer_len) : STORE_DEPTH;
    r = '{8'h00, 1'b0, 32'd0, 32'd0};
    case (c)
      CMD_ADDR_MATCH: bus_phase = PH_ADDRESS;
      CMD_RX_BYTE: begin
        if (bus_phase == PH_ADDRESS) begin
          reg_ptr = b;
        end else if (reg_ptr > 0 && int'(reg_ptr) < lim) begin
          reg_image[reg_ptr] = b;
          reg_ptr = reg_ptr + 8'd1;
        end
        bus_phase = PH_RECEIVE;
      end
      CMD_TX_REQ: begin
        if (int'(reg_ptr) < lim) begin
          r.tx_byte = reg_image[reg_ptr];
          reg_ptr = reg_ptr + 8'd1;
        end else begin
          r.tx_byte = EMPTY_BYTE;
        end
        r.tx_valid = 1'b1;
        bus_phase = PH_TRANSMIT;
      end
      default: begin
        if (bus_phase == PH_TRANSMIT) begin
          read_total = read_total + 32'd1;
        end else if (bus_phase == PH_RECEIVE) begin
          write_total = write_total + 32'd1;
        end
      end
    endcase
    r.write_transfers = write_total;
    r.read_transfers = read_total;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // event driver
  always @(posedge clk) begin
    if (!rst_n) begin
      cmd_if.valid <= 1'b0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        due_replies.push_back(apply_bus_event(bus_events[0].command, bus_events[0].rx_byte));
        void'(bus_events.pop_front());
      end
      if (cmd_if.valid && !cmd_if.ready) begin
        cmd_if.valid <= 1'b1;
      end else if (bus_events.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                   !(bus_events[0].wait_drain && due_replies.size() != 0)) begin
        cmd_if.valid <= 1'b1;
        cmd_if.command <= bus_events[0].command;
        cmd_if.rx_byte <= bus_events[0].rx_byte;
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
  end

  // reply monitor
  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (due_replies.size() == 0) begin
          report_mismatch("reply beat with nothing expected", {24'd0, rsp_if.tx_byte}, 32'd0);
        end else begin
          want = due_replies.pop_front();
          if (rsp_if.tx_byte !== want.tx_byte)
            report_mismatch("tx_byte", {24'd0, rsp_if.tx_byte}, {24'd0, want.tx_byte});
          if (rsp_if.tx_valid !== want.tx_valid)
            report_mismatch("tx_valid", {31'd0, rsp_if.tx_valid}, {31'd0, want.tx_valid});
          if (rsp_if.write_transfers !== want.write_transfers)
            report_mismatch("write_transfers", rsp_if.write_transfers, want.write_transfers);
          if (rsp_if.read_transfers !== want.read_transfers)
            report_mismatch("read_transfers", rsp_if.read_transfers, want.read_transfers);
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic push_event(cmd_e c, logic [7:0] b, bit hold = 1'b0);
    bus_events.push_back('{c, b, hold});
    events_queued++;
  endtask

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_pointer(int len);
    int r;
    int p;
    r = $urandom_range(9);
    if (r < 5) begin
      p = (len > 0) ? $urandom_range(len - 1) : 0;
    end else if (r < 8) begin
      p = len - $urandom_range(3);
    end else begin
      p = $urandom_range(255);
    end
    if (p < 0) p = 0;
    if (p > 255) p = 255;
    return 8'(p);
  endfunction

  task automatic queue_write_burst(int len);
    int n;
    push_event(CMD_ADDR_MATCH, rand_byte(), $urandom_range(49) == 0);
    push_event(CMD_RX_BYTE, pick_pointer(len));
    n = $urandom_range(6);
    repeat (n) push_event(CMD_RX_BYTE, rand_byte());
    push_event(CMD_STOP, rand_byte());
    if ($urandom_range(9) == 0) push_event(CMD_STOP, rand_byte());
  endtask

  task automatic queue_read_burst(int len);
    int n;
    push_event(CMD_ADDR_MATCH, rand_byte(), $urandom_range(49) == 0);
    if ($urandom_range(3) != 0) begin
      push_event(CMD_RX_BYTE, pick_pointer(len));
      push_event(CMD_ADDR_MATCH, rand_byte());
    end
    n = $urandom_range(1, 6);
    repeat (n) push_event(CMD_TX_REQ, rand_byte());
    push_event(CMD_STOP, rand_byte());
    if ($urandom_range(9) == 0) push_event(CMD_STOP, rand_byte());
  endtask

  task automatic queue_noise();
    int n;
    n = $urandom_range(1, 4);
    repeat (n) push_event(cmd_e'($urandom_range(3)), rand_byte());
  endtask

  task automatic wait_drained();
    while (bus_events.size() != 0 || cmd_if.valid || due_replies.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_length(logic [7:0] len);
    wait_drained();
    cfg_if.valid <= 1'b1;
    cfg_if.data <= len;
    do @(posedge clk); while (!cfg_if.ready);
    buffer_len = len;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 16; recv_idle_pct = 88; end
      1: begin send_idle_pct = 88; recv_idle_pct = 16; end
      default: begin send_idle_pct = 0; recv_idle_pct = 0; end
    endcase
  endtask

  initial begin
    int len;
    int target;
    rst_n = 1'b0;
    cmd_if.valid = 1'b0;
    cmd_if.command = CMD_ADDR_MATCH;
    cmd_if.rx_byte = 8'h00;
    cfg_if.valid = 1'b0;
    cfg_if.data = 8'h00;
    rsp_if.ready = 1'b0;
    error_count = 0;
    events_queued = 0;
    buffer_len = 8'd0;
    bus_phase = PH_ADDRESS;
    reg_ptr = 8'd0;
    write_total = 32'd0;
    read_total = 32'd0;
    foreach (reg_image[i]) reg_image[i] = 8'h00;
    set_idling(0);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // zero length straight after reset: reads give the empty byte, writes drop
    push_event(CMD_TX_REQ, 8'hFF);
    push_event(CMD_STOP, 8'h00);
    push_event(CMD_ADDR_MATCH, 8'h00);
    push_event(CMD_RX_BYTE, 8'h05);
    push_event(CMD_RX_BYTE, 8'h33);
    push_event(CMD_STOP, 8'h00);
    push_event(CMD_ADDR_MATCH, 8'h00);
    push_event(CMD_STOP, 8'h00);

    write_length(8'd255);
    push_event(CMD_ADDR_MATCH, 8'h00);
    push_event(CMD_RX_BYTE, 8'h00);
    push_event(CMD_RX_BYTE, 8'hFF);
    push_event(CMD_ADDR_MATCH, 8'h00);
    push_event(CMD_RX_BYTE, 8'h01);
    push_event(CMD_RX_BYTE, 8'hA5);
    push_event(CMD_RX_BYTE, 8'h5A);
    push_event(CMD_STOP, 8'h00);
    push_event(CMD_ADDR_MATCH, 8'h00);
    push_event(CMD_RX_BYTE, 8'h01);
    push_event(CMD_ADDR_MATCH, 8'h00, 1'b1);
    push_event(CMD_TX_REQ, 8'h00);
    push_event(CMD_TX_REQ, 8'h00);
    push_event(CMD_TX_REQ, 8'h00);
    push_event(CMD_STOP, 8'h00);
    push_event(CMD_STOP, 8'h00);
    push_event(CMD_ADDR_MATCH, 8'h00);
    push_event(CMD_RX_BYTE, 8'hFE);
    push_event(CMD_RX_BYTE, 8'hFF);
    push_event(CMD_RX_BYTE, 8'h00);
    push_event(CMD_TX_REQ, 8'h00);
    push_event(CMD_ADDR_MATCH, 8'h00);
    push_event(CMD_RX_BYTE, 8'hFE);
    push_event(CMD_ADDR_MATCH, 8'h00);
    push_event(CMD_TX_REQ, 8'h00);
    push_event(CMD_TX_REQ, 8'h00);
    push_event(CMD_STOP, 8'h00);

    for (int p = 0; p < 9; p++) begin
      len = (PHASE_LEN[p] < 0) ? $urandom_range(3, 253) : PHASE_LEN[p];
      write_length(8'(len));
      set_idling(p / 3);
      target = events_queued + EVENTS_PER_PHASE;
      while (events_queued < target) begin
        case ($urandom_range(19))
          0, 1, 2, 3, 4, 5, 6, 7, 8: queue_write_burst(len);
          9, 10, 11, 12, 13, 14, 15, 16: queue_read_burst(len);
          default: queue_noise();
        endcase
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (due_replies.size() != 0)
      report_mismatch("replies still outstanding", due_replies.size(), 32'd0);
    if (error_count == 0) begin
      $display("tb_i2c_target_register_file: done, clean");
    end else begin
      $display("tb_i2c_target_register_file: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/itrf_pkg.sv
sv/itrf_cfg_if.sv
sv/itrf_cmd_if.sv
sv/itrf_rsp_if.sv
sv/itrf_store.sv
sv/itrf_ctrl.sv
sv/i2c_target_register_file.sv
verif/tb_i2c_target_register_file.sv
